>>> sv/lfr_pkg.sv
package lfr_pkg;

  // default window depth, the longest pattern
  localparam int MAX_PATTERN_DEF = 16;

  // replacement register holds up to sixteen bytes
  localparam int REG_BYTES = 16;

  // configuration register indexes
  localparam logic [2:0] REG_PAT_LO  = 3'd0;
  localparam logic [2:0] REG_PAT_HI  = 3'd1;
  localparam logic [2:0] REG_REP_LO  = 3'd2;
  localparam logic [2:0] REG_REP_HI  = 3'd3;
  localparam logic [2:0] REG_PAT_LEN = 3'd4;
  localparam logic [2:0] REG_REP_LEN = 3'd5;
  localparam logic [2:0] REG_GLOBAL  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // where a new result beat comes from
  typedef enum logic [1:0] {
    SRC_FRONT,
    SRC_REPL,
    SRC_MARK
  } src_t;

  typedef struct packed {
    logic load_item;    // latch line end flag of accepted item
    logic append;       // write incoming byte into window
    logic shift;        // drop window front
    logic push;         // new result beat into hold stage
    src_t src;
    logic finish;       // move held beat out as the last one of the item
    logic repl_start;   // clear window, mark line as replaced
    logic idx_inc;      // next replacement byte
    logic clr_replaced; // line closed
  } cmd_t;

  typedef struct packed {
    logic push_ok;
    logic finish_ok;
    logic full;
    logic count_zero;
    logic emit_need;
    logic repl_hit;
    logic repl_more;
    logic line_end;
  } sts_t;

  // byte i of a 16 byte string split over two 64 bit words
  function automatic logic [7:0] byte_of(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [3:0] i);
    logic [63:0] w;
    w = i[3] ? hi : lo;
    return 8'(w >> {i[2:0], 3'b000});
  endfunction

endpackage

>>> sv/lfr_ctrl.sv
module lfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_byte_present,
  input  logic          in_line_end,
  output logic          in_stall,
  input  lfr_pkg::sts_t sts,
  output lfr_pkg::cmd_t cmd
);

  lfr_pkg::state_t state_r, state_nxt;
  logic            acc;

  // input taken only in idle; a full window must drop its front before taking the byte
  assign in_stall = (state_r != lfr_pkg::ST_IDLE) || (sts.full && !sts.push_ok);
  assign acc      = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfr_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_byte_present)  state_nxt = lfr_pkg::ST_SCAN;
          else if (in_line_end) state_nxt = lfr_pkg::ST_FLUSH;
        end
      end
      lfr_pkg::ST_SCAN: begin
        if (!sts.emit_need) begin
          if (sts.repl_hit)       state_nxt = lfr_pkg::ST_REPL;
          else if (sts.line_end)  state_nxt = lfr_pkg::ST_FLUSH;
          else if (sts.finish_ok) state_nxt = lfr_pkg::ST_IDLE;
        end
      end
      lfr_pkg::ST_REPL: begin
        if (!sts.repl_more) begin
          if (sts.line_end)       state_nxt = lfr_pkg::ST_FLUSH;
          else if (sts.finish_ok) state_nxt = lfr_pkg::ST_IDLE;
        end
      end
      lfr_pkg::ST_FLUSH: begin
        if (sts.count_zero && sts.push_ok) state_nxt = lfr_pkg::ST_DONE;
      end
      lfr_pkg::ST_DONE: begin
        if (sts.finish_ok) state_nxt = lfr_pkg::ST_IDLE;
      end
      default: state_nxt = lfr_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    cmd.src  = lfr_pkg::SRC_FRONT;
    unique case (state_r)
      lfr_pkg::ST_IDLE: begin
        if (acc) begin
          cmd.load_item = 1'b1;
          if (in_byte_present) begin
            cmd.append = 1'b1;
            if (sts.full) begin
              cmd.shift = 1'b1;
              cmd.push  = 1'b1;
            end
          end
        end
      end
      lfr_pkg::ST_SCAN: begin
        if (sts.emit_need) begin
          if (sts.push_ok) begin
            cmd.push  = 1'b1;
            cmd.shift = 1'b1;
          end
        end else if (sts.repl_hit) begin
          cmd.repl_start = 1'b1;
        end else if (!sts.line_end && sts.finish_ok) begin
          cmd.finish = 1'b1;
        end
      end
      lfr_pkg::ST_REPL: begin
        if (sts.repl_more) begin
          if (sts.push_ok) begin
            cmd.push    = 1'b1;
            cmd.src     = lfr_pkg::SRC_REPL;
            cmd.idx_inc = 1'b1;
          end
        end else if (!sts.line_end && sts.finish_ok) begin
          cmd.finish = 1'b1;
        end
      end
      lfr_pkg::ST_FLUSH: begin
        if (sts.push_ok) begin
          cmd.push = 1'b1;
          if (!sts.count_zero) begin
            cmd.shift = 1'b1;
          end else begin
            cmd.src          = lfr_pkg::SRC_MARK;
            cmd.clr_replaced = 1'b1;
          end
        end
      end
      lfr_pkg::ST_DONE: begin
        cmd.finish = sts.finish_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lfr_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> sv/lfr_dp.sv
module lfr_dp #(
  parameter int MAX_PATTERN = lfr_pkg::MAX_PATTERN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // configuration
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  // incoming beat payload
  input  logic [7:0]    in_data_byte,
  input  logic          in_line_end,
  // result channel
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_out_valid,
  output logic          out_line_end,
  output logic          out_last,
  // controller link
  input  lfr_pkg::cmd_t cmd,
  output lfr_pkg::sts_t sts
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  // configuration registers
  logic [63:0] pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
  logic [4:0]  pat_len_r, rep_len_r;
  logic        global_r;

  // window and line state
  logic [MAX_PATTERN-1:0][7:0] win_r, win_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        replaced_r, replaced_nxt;
  logic                        le_r, le_nxt;
  logic [4:0]                  idx_r, idx_nxt;

  // hold stage and output register
  logic       hold_v_r, hold_v_nxt;
  logic [7:0] hold_byte_r, hold_byte_nxt;
  logic       hold_bv_r, hold_bv_nxt;
  logic       hold_le_r, hold_le_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_bv_r, out_bv_nxt;
  logic       out_le_r, out_le_nxt;
  logic       out_last_r, out_last_nxt;

  logic [4:0]       plen, rlen, cnt5;
  logic             en, prefix, out_free;
  logic [MAX_PATTERN-1:0] mism;
  logic [CW-1:0]    wpos;
  logic [7:0]       rep_byte;

  // effective lengths, clamped
  assign plen = (pat_len_r > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : pat_len_r;
  assign rlen = (rep_len_r > 5'(lfr_pkg::REG_BYTES)) ? 5'(lfr_pkg::REG_BYTES) : rep_len_r;
  assign cnt5 = 5'(cnt_r);
  assign en   = (plen != 5'd0) && !(replaced_r && !global_r);

  // pending bytes against the pattern, one comparator per entry
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      mism[i] = (5'(i) < cnt5) &&
                (win_r[i] != lfr_pkg::byte_of(pat_lo_r, pat_hi_r, 4'(i)));
    end
  end
  assign prefix = ~|mism;

  assign rep_byte = lfr_pkg::byte_of(rep_lo_r, rep_hi_r, idx_r[3:0]);
  assign out_free = !out_v_r || !out_stall;

  // status to controller
  always_comb begin
    sts.push_ok    = !hold_v_r || out_free;
    sts.finish_ok  = !hold_v_r || out_free;
    sts.full       = cnt5 >= 5'(MAX_PATTERN);
    sts.count_zero = cnt_r == '0;
    sts.emit_need  = (cnt_r != '0) && (!en || (cnt5 > plen) || !prefix);
    sts.repl_hit   = en && (cnt5 == plen);
    sts.repl_more  = idx_r < rlen;
    sts.line_end   = le_r;
  end

  // window, count and line flags
  always_comb begin
    win_nxt      = cmd.shift ? (win_r >> 8) : win_r;
    wpos         = cmd.shift ? cnt_r - CW'(1) : cnt_r;
    cnt_nxt      = cnt_r + CW'(cmd.append) - CW'(cmd.shift);
    replaced_nxt = replaced_r;
    le_nxt       = cmd.load_item ? in_line_end : le_r;
    idx_nxt      = cmd.idx_inc ? idx_r + 5'd1 : idx_r;
    if (cmd.append) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (CW'(i) == wpos) win_nxt[i] = in_data_byte;
      end
    end
    if (cmd.repl_start) begin
      cnt_nxt      = '0;
      replaced_nxt = 1'b1;
      idx_nxt      = 5'd0;
    end
    if (cmd.clr_replaced) replaced_nxt = 1'b0;
  end

  // hold stage: one beat behind so the last flag is known when it leaves
  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_byte_nxt = hold_byte_r;
    hold_bv_nxt   = hold_bv_r;
    hold_le_nxt   = hold_le_r;
    out_v_nxt     = out_free ? 1'b0 : out_v_r;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_le_nxt    = out_le_r;
    out_last_nxt  = out_last_r;
    if ((cmd.push || cmd.finish) && hold_v_r) begin
      out_v_nxt    = 1'b1;
      out_byte_nxt = hold_byte_r;
      out_bv_nxt   = hold_bv_r;
      out_le_nxt   = hold_le_r;
      out_last_nxt = cmd.finish;
    end
    if (cmd.finish) hold_v_nxt = 1'b0;
    if (cmd.push) begin
      hold_v_nxt = 1'b1;
      case (cmd.src)
        lfr_pkg::SRC_REPL: begin
          hold_byte_nxt = rep_byte;
          hold_bv_nxt   = 1'b1;
          hold_le_nxt   = 1'b0;
        end
        lfr_pkg::SRC_MARK: begin
          hold_byte_nxt = 8'd0;
          hold_bv_nxt   = 1'b0;
          hold_le_nxt   = 1'b1;
        end
        default: begin
          hold_byte_nxt = win_r[0];
          hold_bv_nxt   = 1'b1;
          hold_le_nxt   = 1'b0;
        end
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      rep_lo_r  <= '0;
      rep_hi_r  <= '0;
      pat_len_r <= '0;
      rep_len_r <= '0;
      global_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfr_pkg::REG_PAT_LO:  pat_lo_r  <= cfg_data;
        lfr_pkg::REG_PAT_HI:  pat_hi_r  <= cfg_data;
        lfr_pkg::REG_REP_LO:  rep_lo_r  <= cfg_data;
        lfr_pkg::REG_REP_HI:  rep_hi_r  <= cfg_data;
        lfr_pkg::REG_PAT_LEN: pat_len_r <= cfg_data[4:0];
        lfr_pkg::REG_REP_LEN: rep_len_r <= cfg_data[4:0];
        lfr_pkg::REG_GLOBAL:  global_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      replaced_r <= 1'b0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      replaced_r <= replaced_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    win_r       <= win_nxt;
    le_r        <= le_nxt;
    idx_r       <= idx_nxt;
    hold_byte_r <= hold_byte_nxt;
    hold_bv_r   <= hold_bv_nxt;
    hold_le_r   <= hold_le_nxt;
    out_byte_r  <= out_byte_nxt;
    out_bv_r    <= out_bv_nxt;
    out_le_r    <= out_le_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_byte      = out_byte_r;
  assign out_out_valid = out_bv_r;
  assign out_line_end  = out_le_r;
  assign out_last      = out_last_r;

endmodule

>>> sv/literal_find_replace_stream.sv
// Path: a result beat is registered in the hold stage and then in the output register; each
//   beat waits in the hold stage until the next beat or the close.
// Throughput: one item at a time; input stalls outside idle. A byte item passes idle and scan
//   with one push per result beat (a front byte pushed out of a full window goes out as it is
//   taken); a completed match adds replace, a line end adds flush and done. Output stalls hold it.
// Reset: synchronous, active low; clears pending count, replaced flag, hold/output valid, config.
module literal_find_replace_stream #(
  parameter int MAX_PATTERN = lfr_pkg::MAX_PATTERN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_line_end,
  // result beats; out_out_valid is the byte-carries-data field
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_out_valid,
  output logic        out_line_end,
  output logic        out_last
);

  lfr_pkg::cmd_t cmd;
  lfr_pkg::sts_t sts;

  lfr_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_byte_present (in_byte_present),
    .in_line_end     (in_line_end),
    .in_stall        (in_stall),
    .sts             (sts),
    .cmd             (cmd)
  );

  lfr_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_data_byte  (in_data_byte),
    .in_line_end   (in_line_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_out_valid (out_out_valid),
    .out_line_end  (out_line_end),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

>>> sv/lfr_checker.sv
module lfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_out_valid,
  input logic       out_line_end,
  input logic       out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result beat changed");

  // the line marker carries no byte and closes its item
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end |-> !out_out_valid && out_byte == 8'd0 && out_last)
    else $error("malformed line marker");

  // every beat that is not a marker carries a byte
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_end |-> out_out_valid)
    else $error("result beat without byte or marker");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind literal_find_replace_stream lfr_checker u_lfr_checker (.*);
